### rtl/core/pesort_pkg.sv
// ----------------------------------------------------------------------------
// pesort_pkg
// Shared types and constants for the pinned-element descending sort block.
// ----------------------------------------------------------------------------
package pesort_pkg;

  localparam int VAL_W = 32;
  localparam int OPOS_W = 4;
  localparam int LEN_CFG_W = 5;
  localparam int PIN_CFG_W = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [LEN_CFG_W-1:0] ROW_LENGTH_RST = 5'd16;
  localparam logic [PIN_CFG_W-1:0] PINNED_INDEX_RST = 4'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LENGTH   = 1'b0,
    REG_PINNED_INDEX = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_FORWARD  = 1'b0,
    CMD_BACKWARD = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FLUSH,
    ST_DRAIN,
    ST_BWD
  } state_t;

  typedef struct packed {
    logic               command;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic [OPOS_W-1:0]       origin_position;
    logic                    row_end;
  } out_item_t;

  // Control word broadcast to every cell of the chain.
  typedef struct packed {
    logic clr;
    logic ins;
    logic shf;
  } chain_ctl_t;

endpackage

### rtl/core/pesort_cell.sv
// ----------------------------------------------------------------------------
// pesort_cell
// One insertion cell: holds one sorted entry, takes a new entry or its left
// neighbor's on insert, takes its right neighbor's on shift-out.
// ----------------------------------------------------------------------------
module pesort_cell #(
  parameter int PW = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pesort_pkg::chain_ctl_t            ctl,
  input  logic signed [pesort_pkg::VAL_W-1:0] new_val,
  input  logic [PW-1:0]                     new_pos,
  input  logic                              left_ins,
  input  logic                              left_vld,
  input  logic signed [pesort_pkg::VAL_W-1:0] left_val,
  input  logic [PW-1:0]                     left_pos,
  input  logic                              right_vld,
  input  logic signed [pesort_pkg::VAL_W-1:0] right_val,
  input  logic [PW-1:0]                     right_pos,
  output logic                              my_ins,
  output logic                              vld,
  output logic signed [pesort_pkg::VAL_W-1:0] val,
  output logic [PW-1:0]                     pos
);

  logic                              vld_r;
  logic signed [pesort_pkg::VAL_W-1:0] val_r;
  logic [PW-1:0]                     pos_r;

  // Strict compare keeps equal values in arrival order.
  assign my_ins = !vld_r || (val_r < new_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.clr) begin
      vld_r <= 1'b0;
    end else if (ctl.ins) begin
      if (left_ins) begin
        vld_r <= left_vld;
      end else if (my_ins) begin
        vld_r <= 1'b1;
      end
    end else if (ctl.shf) begin
      vld_r <= right_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (left_ins) begin
        val_r <= left_val;
        pos_r <= left_pos;
      end else if (my_ins) begin
        val_r <= new_val;
        pos_r <= new_pos;
      end
    end else if (ctl.shf) begin
      val_r <= right_val;
      pos_r <= right_pos;
    end
  end

  assign vld = vld_r;
  assign val = val_r;
  assign pos = pos_r;

endmodule

### rtl/core/pesort_chain.sv
// ----------------------------------------------------------------------------
// pesort_chain
// Row of insertion cells kept in descending order; head is cell zero.
// ----------------------------------------------------------------------------
module pesort_chain #(
  parameter int N  = 16,
  parameter int PW = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pesort_pkg::chain_ctl_t            ctl,
  input  logic signed [pesort_pkg::VAL_W-1:0] new_val,
  input  logic [PW-1:0]                     new_pos,
  output logic                              head_vld,
  output logic signed [pesort_pkg::VAL_W-1:0] head_val,
  output logic [PW-1:0]                     head_pos
);

  logic                              ins_w [N];
  logic                              vld_w [N];
  logic signed [pesort_pkg::VAL_W-1:0] val_w [N];
  logic [PW-1:0]                     pos_w [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                              l_ins;
    logic                              l_vld;
    logic signed [pesort_pkg::VAL_W-1:0] l_val;
    logic [PW-1:0]                     l_pos;
    logic                              r_vld;
    logic signed [pesort_pkg::VAL_W-1:0] r_val;
    logic [PW-1:0]                     r_pos;

    if (i == 0) begin : g_first
      assign l_ins = 1'b0;
      assign l_vld = 1'b0;
      assign l_val = '0;
      assign l_pos = '0;
    end else begin : g_mid_l
      assign l_ins = ins_w[i-1];
      assign l_vld = vld_w[i-1];
      assign l_val = val_w[i-1];
      assign l_pos = pos_w[i-1];
    end

    if (i == N - 1) begin : g_last
      assign r_vld = 1'b0;
      assign r_val = '0;
      assign r_pos = '0;
    end else begin : g_mid_r
      assign r_vld = vld_w[i+1];
      assign r_val = val_w[i+1];
      assign r_pos = pos_w[i+1];
    end

    pesort_cell #(.PW(PW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_val   (new_val),
      .new_pos   (new_pos),
      .left_ins  (l_ins),
      .left_vld  (l_vld),
      .left_val  (l_val),
      .left_pos  (l_pos),
      .right_vld (r_vld),
      .right_val (r_val),
      .right_pos (r_pos),
      .my_ins    (ins_w[i]),
      .vld       (vld_w[i]),
      .val       (val_w[i]),
      .pos       (pos_w[i])
    );
  end

  assign head_vld = vld_w[0];
  assign head_val = val_w[0];
  assign head_pos = pos_w[0];

endmodule

### rtl/core/pinned_element_descending_sort.sv
// ----------------------------------------------------------------------------
// pinned_element_descending_sort
// Collects a row of values, emits the pinned element (if inside the row)
// and then the rest in descending order with their origin positions, and
// keeps that permutation to route backward gradients to origin positions.
// ----------------------------------------------------------------------------
//  channel  ports                            handshake
//  input    start, busy, in_item             beat taken when start & !busy
//  result   out_strobe, out_item             one strobe per beat, no stall
//  config   cfg_valid, cfg_ready, cfg_index, write when valid & ready
//           cfg_data
//
// A forward element that does not end a row leaves busy low. The element
// that ends a row keeps busy high through the load state, whose row memory
// reads feed the insertion chain, the flush state, which inserts the last
// one, and the drain state, which shifts the chain out; each result appears
// in the cycle after it leaves the chain. A backward beat reads perm_mem.
// Reset clears control state and the permutation valid bits; the row memory
// is never cleared. The receiver cannot stall, so results never wait.
// ----------------------------------------------------------------------------
module pinned_element_descending_sort #(
  parameter int MAX_ROW = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         start,
  output logic                                         busy,
  input  pesort_pkg::in_item_t                         in_item,
  output logic                                         out_strobe,
  output pesort_pkg::out_item_t                        out_item,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [pesort_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [pesort_pkg::LEN_CFG_W-1:0]             cfg_data
);

  localparam int PW = $clog2(MAX_ROW);
  localparam int LW = $clog2(MAX_ROW + 1);

  pesort_pkg::state_t state_r, state_nxt;

  logic [pesort_pkg::LEN_CFG_W-1:0] row_length_r;
  logic [pesort_pkg::PIN_CFG_W-1:0] pinned_index_r;

  logic [PW-1:0] fill_r;
  logic [PW-1:0] bcount_r;
  logic [PW-1:0] rd_idx_r;
  logic [PW-1:0] oc_r;

  logic [LW-1:0] len;
  logic [PW-1:0] last_idx;
  logic          pinned;
  logic          accept;
  logic          fwd_acc;
  logic          bwd_acc;
  logic          fill_done;
  logic          bwd_end;

  logic signed [pesort_pkg::VAL_W-1:0] row_mem [MAX_ROW];
  logic signed [pesort_pkg::VAL_W-1:0] rd_data_r;
  logic                                ins_vld_r;
  logic [PW-1:0]                       ins_pos_r;
  logic                                pin_hit;
  logic signed [pesort_pkg::VAL_W-1:0] pin_val_r;
  logic [PW-1:0]                       pin_pos_r;

  logic [PW-1:0] perm_mem [MAX_ROW];
  logic          perm_vld_r [MAX_ROW];
  logic [PW-1:0] perm_rd_r;
  logic          perm_rd_vld_r;
  logic [PW-1:0] bidx_r;
  logic          bend_r;
  logic signed [pesort_pkg::VAL_W-1:0] bval_r;

  pesort_pkg::chain_ctl_t chain_ctl;
  logic                                head_vld;
  logic signed [pesort_pkg::VAL_W-1:0] head_val;
  logic [PW-1:0]                       head_pos;

  logic                                pin_slot;
  logic                                perm_we;
  logic [PW-1:0]                       drain_pos;
  logic signed [pesort_pkg::VAL_W-1:0] drain_val;
  logic [PW-1:0]                       bwd_pos;
  logic [PW+pesort_pkg::OPOS_W-1:0]    opos_ext;

  logic                  out_strobe_nxt;
  pesort_pkg::out_item_t out_item_nxt;
  logic                  out_strobe_r;
  pesort_pkg::out_item_t out_item_r;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r   <= pesort_pkg::ROW_LENGTH_RST;
      pinned_index_r <= pesort_pkg::PINNED_INDEX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (pesort_pkg::cfg_reg_t'(cfg_index))
        pesort_pkg::REG_ROW_LENGTH:   row_length_r <= cfg_data;
        pesort_pkg::REG_PINNED_INDEX: pinned_index_r <= cfg_data[pesort_pkg::PIN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the row length to 1..MAX_ROW.
  always_comb begin
    if (row_length_r == '0) begin
      len = LW'(1);
    end else if (32'(row_length_r) > MAX_ROW) begin
      len = LW'(MAX_ROW);
    end else begin
      len = LW'(row_length_r);
    end
  end

  assign last_idx = PW'(len - LW'(1));
  assign pinned   = {{LW{1'b0}}, pinned_index_r}
                    < {{pesort_pkg::PIN_CFG_W{1'b0}}, len};

  // --------------------------------------------------------------------------
  // Input acceptance
  // --------------------------------------------------------------------------
  assign accept    = start && !busy;
  assign fwd_acc   = accept && (in_item.command == pesort_pkg::CMD_FORWARD);
  assign bwd_acc   = accept && (in_item.command == pesort_pkg::CMD_BACKWARD);
  assign fill_done = ((PW+1)'(fill_r) + (PW+1)'(1)) >= (PW+1)'(len);
  assign bwd_end   = ((PW+1)'(bcount_r) + (PW+1)'(1)) >= (PW+1)'(len);

  // --------------------------------------------------------------------------
  // State machine
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pesort_pkg::ST_IDLE: begin
        if (fwd_acc && fill_done) begin
          state_nxt = pesort_pkg::ST_LOAD;
        end else if (bwd_acc) begin
          state_nxt = pesort_pkg::ST_BWD;
        end
      end
      pesort_pkg::ST_LOAD: begin
        if (rd_idx_r == last_idx) begin
          state_nxt = pesort_pkg::ST_FLUSH;
        end
      end
      pesort_pkg::ST_FLUSH: state_nxt = pesort_pkg::ST_DRAIN;
      pesort_pkg::ST_DRAIN: begin
        if (oc_r == last_idx) begin
          state_nxt = pesort_pkg::ST_IDLE;
        end
      end
      pesort_pkg::ST_BWD: state_nxt = pesort_pkg::ST_IDLE;
      default: state_nxt = pesort_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pesort_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Outputs of the state machine
  always_comb begin
    busy           = (state_r != pesort_pkg::ST_IDLE);
    pin_slot       = pinned && (oc_r == '0);
    pin_hit        = pinned && ({{pesort_pkg::PIN_CFG_W{1'b0}}, ins_pos_r}
                                == {{PW{1'b0}}, pinned_index_r});
    chain_ctl.clr  = fwd_acc && fill_done;
    chain_ctl.ins  = ins_vld_r && !pin_hit;
    chain_ctl.shf  = (state_r == pesort_pkg::ST_DRAIN) && !pin_slot;
    perm_we        = (state_r == pesort_pkg::ST_DRAIN);
    drain_pos      = pin_slot ? pin_pos_r : head_pos;
    drain_val      = pin_slot ? pin_val_r : head_val;
    bwd_pos        = perm_rd_vld_r ? perm_rd_r : bidx_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = '0;
    opos_ext       = '0;
    case (state_r)
      pesort_pkg::ST_DRAIN: begin
        opos_ext                     = {{pesort_pkg::OPOS_W{1'b0}}, drain_pos};
        out_strobe_nxt               = 1'b1;
        out_item_nxt.result_value    = drain_val;
        out_item_nxt.origin_position = opos_ext[pesort_pkg::OPOS_W-1:0];
        out_item_nxt.row_end         = (oc_r == last_idx);
      end
      pesort_pkg::ST_BWD: begin
        opos_ext                     = {{pesort_pkg::OPOS_W{1'b0}}, bwd_pos};
        out_strobe_nxt               = 1'b1;
        out_item_nxt.result_value    = bval_r;
        out_item_nxt.origin_position = opos_ext[pesort_pkg::OPOS_W-1:0];
        out_item_nxt.row_end         = bend_r;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Counters
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      bcount_r  <= '0;
      rd_idx_r  <= '0;
      oc_r      <= '0;
      ins_vld_r <= 1'b0;
    end else begin
      ins_vld_r <= (state_r == pesort_pkg::ST_LOAD);
      if (fwd_acc) begin
        bcount_r <= '0;
        if (fill_done) begin
          fill_r   <= '0;
          rd_idx_r <= '0;
          oc_r     <= '0;
        end else begin
          fill_r <= fill_r + PW'(1);
        end
      end else if (bwd_acc) begin
        fill_r   <= '0;
        bcount_r <= bwd_end ? '0 : bcount_r + PW'(1);
      end
      if (state_r == pesort_pkg::ST_LOAD) begin
        rd_idx_r <= rd_idx_r + PW'(1);
      end
      if (state_r == pesort_pkg::ST_DRAIN) begin
        oc_r <= oc_r + PW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Row memory: written per forward beat, read back in position order
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (fwd_acc) begin
      row_mem[fill_r] <= in_item.value;
    end
    rd_data_r <= row_mem[rd_idx_r];
    ins_pos_r <= rd_idx_r;
  end

  // Hold the pinned element aside; it leaves first.
  always_ff @(posedge clk) begin
    if (ins_vld_r && pin_hit) begin
      pin_val_r <= rd_data_r;
      pin_pos_r <= ins_pos_r;
    end
  end

  pesort_chain #(.N(MAX_ROW), .PW(PW)) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (chain_ctl),
    .new_val  (rd_data_r),
    .new_pos  (ins_pos_r),
    .head_vld (head_vld),
    .head_val (head_val),
    .head_pos (head_pos)
  );

  // --------------------------------------------------------------------------
  // Permutation memory; an entry never written reads as its own index
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[oc_r] <= drain_pos;
    end
    perm_rd_r <= perm_mem[bcount_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_ROW; k++) begin
        perm_vld_r[k] <= 1'b0;
      end
      perm_rd_vld_r <= 1'b0;
    end else begin
      if (perm_we) begin
        perm_vld_r[oc_r] <= 1'b1;
      end
      perm_rd_vld_r <= perm_vld_r[bcount_r];
    end
  end

  always_ff @(posedge clk) begin
    if (bwd_acc) begin
      bidx_r <= bcount_r;
      bend_r <= bwd_end;
      bval_r <= in_item.value;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef SYNTH
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == pesort_pkg::ST_DRAIN
                    || $past(state_r) == pesort_pkg::ST_BWD))
    else $error("result beat without a drain or backward cycle");

  a_head_vld: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pesort_pkg::ST_DRAIN && !pin_slot) |-> head_vld)
    else $error("chain empty while draining a sorted entry");

  a_ins_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pesort_pkg::ST_IDLE) |-> !ins_vld_r)
    else $error("insertion pending while idle");

  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    chain_ctl.clr |-> (state_r == pesort_pkg::ST_IDLE && !ins_vld_r))
    else $error("chain cleared while a row is in flight");
`endif

endmodule
